// ===== hw/rtl/sltd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sltd_pkg: shared types and constants of the sync/length/tail deframer
// Holds the parser phase type, the result kind codes and the fixed byte
// values of the frame format.
// ----------------------------------------------------------------------------
package sltd_pkg;

    typedef enum logic [3:0] {
        PH_HUNT1 = 4'd0,
        PH_HUNT2 = 4'd1,
        PH_TYPE0 = 4'd2,
        PH_TYPE1 = 4'd3,
        PH_SRC   = 4'd4,
        PH_TGT   = 4'd5,
        PH_LEN   = 4'd6,
        PH_PAY   = 4'd7,
        PH_TAIL1 = 4'd8,
        PH_TAIL2 = 4'd9
    } phase_t;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_TYPE     = 3'd0;
    localparam kind_t KIND_SRC_ID   = 3'd1;
    localparam kind_t KIND_TGT_ID   = 3'd2;
    localparam kind_t KIND_PAYLOAD  = 3'd3;
    localparam kind_t KIND_GOOD_END = 3'd4;
    localparam kind_t KIND_BAD_TAIL = 3'd5;
    localparam kind_t KIND_TOO_LONG = 3'd6;

    localparam logic [7:0]  SYNC_FIRST    = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND   = 8'hFE;
    localparam logic [7:0]  TAIL_BYTE     = 8'hFF;
    localparam logic [1:0]  LEN_LAST_BYTE = 2'd3;
    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

endpackage : sltd_pkg
`default_nettype wire

// ===== hw/rtl/sync_length_tail_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_tail_deframer: byte-serial frame parser
// Hunts for the sync pair, then parses type, identifiers, length, payload
// and tail, producing at most one result item per received byte.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle unless a held result is stalled at the output;
// the output register lets a new byte in while the previous result is being taken.
// Reset: parser hunts for the first sync byte, output is empty and the
// maximum payload length returns to 1048576.
module sync_length_tail_deframer #(
    parameter int ID_BYTES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output sltd_pkg::kind_t  kind,
    output logic [7:0]       byte_value,
    output logic [15:0]      frame_type,
    output logic [31:0]      payload_length,
    output logic             last,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);
    import sltd_pkg::*;

    localparam int CNT_W = (ID_BYTES > 4) ? $clog2(ID_BYTES) : 2;
    localparam logic [CNT_W-1:0] ID_LAST = CNT_W'(ID_BYTES - 1);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  field_cnt_reg, field_cnt_next;
    logic [15:0]       type_reg, type_next;
    logic [31:0]       len_reg, len_next;
    logic [31:0]       pay_cnt_reg, pay_cnt_next;
    logic              id_ended_reg, id_ended_next;
    logic              tail_ok_reg, tail_ok_next;
    logic [31:0]       max_len_reg;

    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [7:0]        byte_reg;
    logic [15:0]       frame_type_reg;
    logic [31:0]       length_reg;

    logic              in_acc;
    logic              res_valid;
    kind_t             res_kind;
    logic [7:0]        res_byte;

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            field_cnt_reg <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            pay_cnt_reg   <= '0;
            id_ended_reg  <= 1'b0;
            tail_ok_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            phase_reg     <= phase_next;
            field_cnt_reg <= field_cnt_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            pay_cnt_reg   <= pay_cnt_next;
            id_ended_reg  <= id_ended_next;
            tail_ok_reg   <= tail_ok_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        field_cnt_next = field_cnt_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        pay_cnt_next   = pay_cnt_reg;
        id_ended_next  = id_ended_reg;
        tail_ok_next   = tail_ok_reg;
        res_valid      = 1'b0;
        res_kind       = KIND_TYPE;
        res_byte       = '0;

        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (in_byte == SYNC_SECOND)
                begin
                    phase_next     = PH_TYPE0;
                    type_next      = '0;
                    len_next       = '0;
                    pay_cnt_next   = '0;
                    field_cnt_next = '0;
                    id_ended_next  = 1'b0;
                    tail_ok_next   = 1'b0;
                end
                else if (in_byte != SYNC_FIRST)
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_TYPE0:
            begin
                type_next  = {8'h00, in_byte};
                phase_next = PH_TYPE1;
            end
            PH_TYPE1:
            begin
                type_next      = {in_byte, type_reg[7:0]};
                res_valid      = 1'b1;
                res_kind       = KIND_TYPE;
                field_cnt_next = '0;
                id_ended_next  = 1'b0;
                phase_next     = PH_SRC;
            end
            PH_SRC, PH_TGT:
            begin
                if (!id_ended_reg && in_byte != 8'h00)
                begin
                    res_valid = 1'b1;
                    res_kind  = (phase_reg == PH_SRC) ? KIND_SRC_ID : KIND_TGT_ID;
                    res_byte  = in_byte;
                end
                else
                begin
                    id_ended_next = 1'b1;
                end
                field_cnt_next = field_cnt_reg + 1'b1;
                if (field_cnt_reg == ID_LAST)
                begin
                    field_cnt_next = '0;
                    id_ended_next  = 1'b0;
                    phase_next     = (phase_reg == PH_SRC) ? PH_TGT : PH_LEN;
                end
            end
            PH_LEN:
            begin
                case (field_cnt_reg[1:0])
                    2'd0:    len_next = len_reg | {24'h000000, in_byte};
                    2'd1:    len_next = len_reg | {16'h0000, in_byte, 8'h00};
                    2'd2:    len_next = len_reg | {8'h00, in_byte, 16'h0000};
                    default: len_next = len_reg | {in_byte, 24'h000000};
                endcase
                field_cnt_next = field_cnt_reg + 1'b1;
                if (field_cnt_reg[1:0] == LEN_LAST_BYTE)
                begin
                    field_cnt_next = '0;
                    pay_cnt_next   = '0;
                    if (len_next > max_len_reg)
                    begin
                        res_valid  = 1'b1;
                        res_kind   = KIND_TOO_LONG;
                        phase_next = PH_HUNT1;
                    end
                    else if (len_next == 32'd0)
                    begin
                        phase_next = PH_TAIL1;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                res_valid    = 1'b1;
                res_kind     = KIND_PAYLOAD;
                res_byte     = in_byte;
                pay_cnt_next = pay_cnt_reg + 32'd1;
                if (pay_cnt_next == len_reg)
                begin
                    phase_next = PH_TAIL1;
                end
            end
            PH_TAIL1:
            begin
                tail_ok_next = (in_byte == TAIL_BYTE);
                phase_next   = PH_TAIL2;
            end
            PH_TAIL2:
            begin
                res_valid  = 1'b1;
                res_kind   = (tail_ok_reg && in_byte == TAIL_BYTE) ? KIND_GOOD_END
                                                                   : KIND_BAD_TAIL;
                phase_next = PH_HUNT1;
            end
            default:
            begin
                phase_next = (in_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && res_valid)
        begin
            kind_reg       <= res_kind;
            byte_reg       <= res_byte;
            frame_type_reg <= type_next;
            length_reg     <= (res_kind == KIND_TYPE || res_kind == KIND_SRC_ID ||
                               res_kind == KIND_TGT_ID) ? 32'd0 : len_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign byte_value     = byte_reg;
    assign frame_type     = frame_type_reg;
    assign payload_length = length_reg;
    assign last           = (kind_reg == KIND_GOOD_END) || (kind_reg == KIND_BAD_TAIL) ||
                            (kind_reg == KIND_TOO_LONG);

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled while no result is held");

    a_field_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SRC || phase_reg == PH_TGT) |-> (field_cnt_reg <= ID_LAST))
        else $error("identifier byte count out of range");

    a_payload_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (pay_cnt_reg < len_reg))
        else $error("payload count reached length inside payload phase");

    a_too_long_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && res_valid && res_kind == KIND_TOO_LONG) |=> (phase_reg == PH_HUNT1))
        else $error("parser did not resume hunting after an oversize length");

    a_type_then_source: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && res_valid && res_kind == KIND_TYPE)
            |=> (phase_reg == PH_SRC && field_cnt_reg == '0 && out_valid_reg))
        else $error("type result not followed by the source identifier field");

endmodule : sync_length_tail_deframer
`default_nettype wire
